### hdl/wss_pkg.sv
// Shared types and constants for the windowed sample statistics block.
// Used by wss_ctrl, wss_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package wss_pkg;

  localparam int DEFAULT_WINDOW = 20;

  localparam int SAMPLE_W    = 10;
  localparam int SUM_OUT_W   = 15;
  localparam int CNT_OUT_W   = 5;
  localparam int TENTHS_W    = 6;

  localparam int SAMPLE_MAX    = 1023;
  localparam int SUM_OUT_MAX   = 32767;
  localparam int COUNT_OUT_MAX = 31;

  // tenths = floor(x * 100 / 2046)
  localparam int TENTHS_NUM   = 100;
  localparam int TENTHS_NUM_W = 7;
  localparam int TENTHS_DEN   = 2046;
  localparam int TENTHS_DEN_W = 11;

  // single samples scale by a reciprocal multiply: (x * MUL) >> SHIFT gives
  // floor(x * 100 / 2046) exactly for every 10-bit sample
  localparam int TENTHS_SHIFT = 21;
  localparam int TENTHS_MUL_W = 17;
  localparam int TENTHS_MUL   = ((TENTHS_NUM << TENTHS_SHIFT) / TENTHS_DEN) + 1;

  typedef struct packed {
    logic       cap;       // take the input sample, start the ring read
    logic       upd;       // update window, max and min
    logic       div_load;  // load numerator and divisor
    logic       div_step;  // one quotient bit
    logic       out_load;  // move results into the output register
  } wss_cmd_t;

  typedef struct packed {
    logic out_free;        // output register can take a new result
  } wss_stat_t;

endpackage

### hdl/windowed_sample_statistics.sv
// Windowed sample statistics, 10-bit samples: one input transfer gives one
// result transfer of raw and scaled figures. Each sample passes through a
// capture, a window update, an operand load and six steps of the restoring
// divider for the average tenths, and an output load; the current, max and
// min tenths come from a reciprocal multiply at the output load. A new
// sample is taken only once the last one has been loaded for output. The
// output register holds a finished result while the next sample is taken;
// a result still waiting there when the next one is ready holds the block
// until it is transferred.
// Depends on wss_pkg, wss_ctrl and wss_datapath.
`timescale 1ns / 1ps

module windowed_sample_statistics #(
  parameter int WINDOW = wss_pkg::DEFAULT_WINDOW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wss_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wss_pkg::SAMPLE_W-1:0]   out_current_raw,
  output logic [wss_pkg::SAMPLE_W-1:0]   out_max_raw,
  output logic [wss_pkg::SAMPLE_W-1:0]   out_min_raw,
  output logic [wss_pkg::SUM_OUT_W-1:0]  out_window_sum,
  output logic [wss_pkg::CNT_OUT_W-1:0]  out_window_count,
  output logic [wss_pkg::TENTHS_W-1:0]   out_current_tenths,
  output logic [wss_pkg::TENTHS_W-1:0]   out_max_tenths,
  output logic [wss_pkg::TENTHS_W-1:0]   out_min_tenths,
  output logic [wss_pkg::TENTHS_W-1:0]   out_avg_tenths
);
  import wss_pkg::*;

  wss_cmd_t  cmd;
  wss_stat_t stat;

  wss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wss_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_current_raw    (out_current_raw),
    .out_max_raw        (out_max_raw),
    .out_min_raw        (out_min_raw),
    .out_window_sum     (out_window_sum),
    .out_window_count   (out_window_count),
    .out_current_tenths (out_current_tenths),
    .out_max_tenths     (out_max_tenths),
    .out_min_tenths     (out_min_tenths),
    .out_avg_tenths     (out_avg_tenths)
  );

endmodule

### hdl/wss_ctrl.sv
// Controller for the windowed sample statistics block.
// Sequences capture, window update, the divider run for the average and the
// output load. Depends on wss_pkg.
`timescale 1ns / 1ps

module wss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wss_pkg::wss_stat_t  stat,
  output wss_pkg::wss_cmd_t   cmd
);
  import wss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int         STEP_W    = $clog2(TENTHS_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TENTHS_W - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the previous result has been transferred
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### hdl/wss_datapath.sv
// Datapath for the windowed sample statistics block: ring store, running
// sum, extremes, a restoring divider for the average, reciprocal scaling and
// the output register. Depends on wss_pkg; driven by wss_ctrl.
`timescale 1ns / 1ps

module wss_datapath #(
  parameter int WINDOW = wss_pkg::DEFAULT_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wss_pkg::wss_cmd_t                   cmd,
  output wss_pkg::wss_stat_t                  stat,
  input  logic [wss_pkg::SAMPLE_W-1:0]        in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wss_pkg::SAMPLE_W-1:0]        out_current_raw,
  output logic [wss_pkg::SAMPLE_W-1:0]        out_max_raw,
  output logic [wss_pkg::SAMPLE_W-1:0]        out_min_raw,
  output logic [wss_pkg::SUM_OUT_W-1:0]       out_window_sum,
  output logic [wss_pkg::CNT_OUT_W-1:0]       out_window_count,
  output logic [wss_pkg::TENTHS_W-1:0]        out_current_tenths,
  output logic [wss_pkg::TENTHS_W-1:0]        out_max_tenths,
  output logic [wss_pkg::TENTHS_W-1:0]        out_min_tenths,
  output logic [wss_pkg::TENTHS_W-1:0]        out_avg_tenths
);
  import wss_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int DIV_W  = SUM_W + TENTHS_NUM_W;
  localparam int DEN_W  = TENTHS_DEN_W + CNT_W;
  localparam int SUM_X_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int CNT_X_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int PROD_W  = SAMPLE_W + TENTHS_MUL_W;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW - 1);

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    fill_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] max_r, min_r, samp_r;

  logic [DIV_W-1:0]    rem_r, den_r;
  logic [TENTHS_W-1:0] q_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_cur_r, out_max_r, out_min_r;
  logic [SUM_OUT_W-1:0] out_sum_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [TENTHS_W-1:0] out_ct_r, out_mt_r, out_nt_r, out_at_r;

  logic                full;
  logic [SUM_W-1:0]    sum_nxt;
  logic [DIV_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic                ge;
  logic [TENTHS_W-1:0] q_nxt;
  logic [SUM_X_W-1:0]  sum_x;
  logic [CNT_X_W-1:0]  cnt_x;

  // scale one sample to tenths of a volt
  function automatic logic [TENTHS_W-1:0] to_tenths(input logic [SAMPLE_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(TENTHS_MUL);
    return prod[TENTHS_SHIFT +: TENTHS_W];
  endfunction

  // ring store: read the oldest entry at capture, write the new one at update
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      rd_data_r <= ring_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      ring_mem[wr_ptr_r] <= samp_r;
    end
  end

  assign full    = (fill_r == FULL_CNT);
  assign sum_nxt = sum_r + SUM_W'(samp_r) - (full ? SUM_W'(rd_data_r) : '0);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      samp_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      max_r    <= '0;
      min_r    <= SAMPLE_W'(SAMPLE_MAX);
    end else if (cmd.upd) begin
      wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      if (full) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      end else begin
        fill_r <= fill_r + 1'b1;
      end
      sum_r <= sum_nxt;
      if (samp_r > max_r) begin
        max_r <= samp_r;
      end
      if (samp_r < min_r) begin
        min_r <= samp_r;
      end
    end
  end

  // average: sum * 100 over count * 2046
  assign num = DIV_W'(sum_r) * DIV_W'(TENTHS_NUM);
  assign den = DEN_W'(fill_r) * DEN_W'(TENTHS_DEN);

  // quotient is below 64, so six restoring steps are enough
  assign ge    = (rem_r >= den_r);
  assign q_nxt = {q_r[TENTHS_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= num;
      den_r <= DIV_W'(den) << (TENTHS_W - 1);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      den_r <= den_r >> 1;
      q_r   <= q_nxt;
    end
  end

  // saturate the raw window figures to their port widths
  assign sum_x = SUM_X_W'(sum_r);
  assign cnt_x = CNT_X_W'(fill_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cur_r <= samp_r;
      out_max_r <= max_r;
      out_min_r <= min_r;
      out_sum_r <= (sum_x > SUM_X_W'(SUM_OUT_MAX)) ? SUM_OUT_W'(SUM_OUT_MAX)
                                                   : sum_x[SUM_OUT_W-1:0];
      out_cnt_r <= (cnt_x > CNT_X_W'(COUNT_OUT_MAX)) ? CNT_OUT_W'(COUNT_OUT_MAX)
                                                     : cnt_x[CNT_OUT_W-1:0];
      out_ct_r  <= to_tenths(samp_r);
      out_mt_r  <= to_tenths(max_r);
      out_nt_r  <= to_tenths(min_r);
      out_at_r  <= q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_current_raw    = out_cur_r;
  assign out_max_raw        = out_max_r;
  assign out_min_raw        = out_min_r;
  assign out_window_sum     = out_sum_r;
  assign out_window_count   = out_cnt_r;
  assign out_current_tenths = out_ct_r;
  assign out_max_tenths     = out_mt_r;
  assign out_min_tenths     = out_nt_r;
  assign out_avg_tenths     = out_at_r;

endmodule

### hdl/wss_checker.sv
// Port-level checks for windowed_sample_statistics, attached by bind.
// Depends on wss_pkg.
`timescale 1ns / 1ps

module wss_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wss_pkg::SAMPLE_W-1:0]   out_current_raw,
  input logic [wss_pkg::SAMPLE_W-1:0]   out_max_raw,
  input logic [wss_pkg::SAMPLE_W-1:0]   out_min_raw,
  input logic [wss_pkg::SUM_OUT_W-1:0]  out_window_sum,
  input logic [wss_pkg::CNT_OUT_W-1:0]  out_window_count,
  input logic [wss_pkg::TENTHS_W-1:0]   out_current_tenths,
  input logic [wss_pkg::TENTHS_W-1:0]   out_max_tenths,
  input logic [wss_pkg::TENTHS_W-1:0]   out_min_tenths,
  input logic [wss_pkg::TENTHS_W-1:0]   out_avg_tenths
);
  import wss_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_raw)
      && $stable(out_window_sum) && $stable(out_avg_tenths))
    else $error("result changed while stalled");

  // one sample in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // the current sample lies between the running extremes
  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_raw <= out_current_raw && out_current_raw <= out_max_raw
      && out_min_tenths <= out_max_tenths)
    else $error("extremes do not bracket the current sample");

  // the window is never empty and the average stays within full scale
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_window_count != '0
      && out_avg_tenths <= TENTHS_W'(TENTHS_NUM / 2)
      && out_current_tenths <= TENTHS_W'(TENTHS_NUM / 2))
    else $error("window count or scaled value out of range");

endmodule

bind windowed_sample_statistics wss_checker u_wss_checker (.*);
